/* design/rau_pkg.sv */
// Shared types, codes and datapath command set of the rational arithmetic unit.
package rau_pkg;

  localparam int CMD_BITS  = 4;
  localparam int NUM_BITS  = 32;
  localparam int DEN_BITS  = 31;
  localparam int STAT_BITS = 2;

  localparam logic [CMD_BITS-1:0] CMD_NORM = 4'd0;
  localparam logic [CMD_BITS-1:0] CMD_ADD  = 4'd1;
  localparam logic [CMD_BITS-1:0] CMD_SUB  = 4'd2;
  localparam logic [CMD_BITS-1:0] CMD_MUL  = 4'd3;
  localparam logic [CMD_BITS-1:0] CMD_DIV  = 4'd4;
  localparam logic [CMD_BITS-1:0] CMD_NEG  = 4'd5;
  localparam logic [CMD_BITS-1:0] CMD_EQ   = 4'd6;
  localparam logic [CMD_BITS-1:0] CMD_NE   = 4'd7;
  localparam logic [CMD_BITS-1:0] CMD_LT   = 4'd8;
  localparam logic [CMD_BITS-1:0] CMD_GT   = 4'd9;

  localparam logic [STAT_BITS-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_DIV0 = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [CMD_BITS-1:0]        cmd;
    logic signed [NUM_BITS-1:0] a_num;
    logic signed [NUM_BITS-1:0] a_den;
    logic signed [NUM_BITS-1:0] b_num;
    logic signed [NUM_BITS-1:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [NUM_BITS-1:0] res_num;
    logic [DEN_BITS-1:0]        res_den;
    logic                       cmp_true;
    logic [STAT_BITS-1:0]       status;
  } rau_out_t;

  typedef enum logic [5:0] {
    OP_NOP,
    OP_LOAD,
    OP_R_FROM_A,
    OP_R_FROM_B,
    OP_A_FROM_R,
    OP_B_FROM_R,
    OP_NEG,
    OP_GCD_R,
    OP_GCD_D,
    OP_GCD_STEP,
    OP_GCD_FIN,
    OP_DIV_RM,
    OP_DIV_RD,
    OP_DIV_AD,
    OP_DIV_BD,
    OP_DIV_STEP,
    OP_WB_RM,
    OP_WB_RD,
    OP_WB_Q1,
    OP_WB_Q2,
    OP_MUL_T1,
    OP_MUL_T2,
    OP_MUL_DEN,
    OP_MUL_MM,
    OP_MUL_DD,
    OP_MUL_MD,
    OP_MUL_DM,
    OP_MUL_CX,
    OP_MUL_CY,
    OP_ADD_COMB,
    OP_FIN_ARITH,
    OP_FIN_CMP,
    OP_FIN_ERR,
    OP_FIN_ZERO
  } dp_op_t;

  typedef struct packed {
    logic [CMD_BITS-1:0] cmd;
    logic                a_den_zero;
    logic                b_den_zero;
    logic                b_mag_zero;
    logic                gcd_done;
    logic                div_done;
  } rau_stat_t;

endpackage

/* design/rational_arithmetic_unit_top.sv */
// A zero denominator or an unused opcode goes straight to the result; each reduction is
// a gcd followed by two radix-2 divides (numerator and denominator by the gcd);
// norm/neg reduce once, compares twice, mul/div three times, add/sub three
// times plus a denominator gcd and two divides.
// One transaction in flight; the next is taken while a result waits in the
// output register. Sync active-high reset clears sequencer and output valid only.
module rational_arithmetic_unit_top #(
  parameter int WORD_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rau_pkg::rau_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rau_pkg::rau_out_t out_data
);
  import rau_pkg::*;

  dp_op_t    op;
  rau_stat_t stat;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .op        (op)
  );

  rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .op       (op),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

/* design/rau_datapath.sv */
// Operand, gcd, divider, multiplier and result registers of the rational unit.
module rau_datapath #(
  parameter int WORD_BITS = 32
) (
  input  logic             clk,
  input  rau_pkg::rau_in_t in_data,
  input  rau_pkg::dp_op_t  op,
  output rau_pkg::rau_stat_t stat,
  output rau_pkg::rau_out_t  out_data
);
  import rau_pkg::*;

  localparam int W     = WORD_BITS;
  localparam int DW    = 2 * WORD_BITS;
  localparam int SHW   = $clog2(DW);
  localparam int CNTW  = $clog2(DW) + 1;
  localparam logic [DW-1:0] HALF = DW'(1) << (W - 1);

  logic [CMD_BITS-1:0] cmd;
  logic          a_neg, b_neg, a_dz, b_dz;
  logic [W-1:0]  a_mag, a_den, b_mag, b_den;
  logic          r_neg;
  logic [DW-1:0] r_mag, r_den;
  logic [DW-1:0] t1, t2;
  logic [W-1:0]  q1, q2;
  logic [DW-1:0] g, gx, gy;
  logic [SHW-1:0] sh;
  logic [DW-1:0] dv_q, dv_rem;
  logic [CNTW-1:0] dv_cnt;
  rau_out_t      res;

  logic signed [W-1:0] an_w, ad_w, bn_w, bd_w;
  logic [W-1:0]  mul_x, mul_y;
  logic [DW-1:0] prod;
  logic [DW:0]   rem_sh, rem_sub;
  logic          bneg_eff;
  logic signed [DW:0] cx, cy;
  logic signed [W-1:0] rnum_w;
  logic          ovf;

  assign an_w = in_data.a_num[W-1:0];
  assign ad_w = in_data.a_den[W-1:0];
  assign bn_w = in_data.b_num[W-1:0];
  assign bd_w = in_data.b_den[W-1:0];

  // one shared multiplier, product always lands in a register
  always_comb begin
    unique case (op)
      OP_MUL_T1:  begin mul_x = a_mag; mul_y = q1;    end
      OP_MUL_T2:  begin mul_x = b_mag; mul_y = q2;    end
      OP_MUL_DEN: begin mul_x = q2;    mul_y = b_den; end
      OP_MUL_MM:  begin mul_x = a_mag; mul_y = b_mag; end
      OP_MUL_DD:  begin mul_x = a_den; mul_y = b_den; end
      OP_MUL_MD,
      OP_MUL_CX:  begin mul_x = a_mag; mul_y = b_den; end
      OP_MUL_DM,
      OP_MUL_CY:  begin mul_x = a_den; mul_y = b_mag; end
      default:    begin mul_x = a_mag; mul_y = b_den; end
    endcase
  end
  assign prod = DW'(mul_x) * DW'(mul_y);

  assign rem_sh  = {dv_rem, dv_q[DW-1]};
  assign rem_sub = rem_sh - {1'b0, g};

  assign bneg_eff = (cmd == CMD_SUB) ? ((b_mag != '0) && !b_neg) : b_neg;

  assign cx = a_neg ? -$signed({1'b0, t1}) : $signed({1'b0, t1});
  assign cy = b_neg ? -$signed({1'b0, t2}) : $signed({1'b0, t2});

  assign rnum_w = r_neg ? W'(-r_mag[W-1:0]) : r_mag[W-1:0];
  assign ovf = (r_den > HALF - 1'b1) || (r_neg ? (r_mag > HALF) : (r_mag > HALF - 1'b1));

  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        cmd   <= in_data.cmd;
        a_neg <= an_w[W-1] ^ ad_w[W-1];
        a_mag <= an_w[W-1] ? W'(-an_w) : W'(an_w);
        a_den <= ad_w[W-1] ? W'(-ad_w) : W'(ad_w);
        b_neg <= bn_w[W-1] ^ bd_w[W-1];
        b_mag <= bn_w[W-1] ? W'(-bn_w) : W'(bn_w);
        b_den <= bd_w[W-1] ? W'(-bd_w) : W'(bd_w);
        a_dz  <= (ad_w == '0);
        b_dz  <= (bd_w == '0);
      end
      OP_R_FROM_A: begin
        r_neg <= a_neg; r_mag <= DW'(a_mag); r_den <= DW'(a_den);
      end
      OP_R_FROM_B: begin
        r_neg <= b_neg; r_mag <= DW'(b_mag); r_den <= DW'(b_den);
      end
      OP_A_FROM_R: begin
        a_neg <= r_neg; a_mag <= r_mag[W-1:0]; a_den <= r_den[W-1:0];
      end
      OP_B_FROM_R: begin
        b_neg <= r_neg; b_mag <= r_mag[W-1:0]; b_den <= r_den[W-1:0];
      end
      OP_NEG: begin
        r_neg <= (a_mag != '0) && !a_neg; r_mag <= DW'(a_mag); r_den <= DW'(a_den);
      end
      OP_GCD_R: begin gx <= r_mag; gy <= r_den; sh <= '0; end
      OP_GCD_D: begin gx <= DW'(a_den); gy <= DW'(b_den); sh <= '0; end
      OP_GCD_STEP: begin
        priority if (!gx[0] && !gy[0]) begin
          gx <= gx >> 1; gy <= gy >> 1; sh <= sh + 1'b1;
        end else if (!gx[0]) begin
          gx <= gx >> 1;
        end else if (!gy[0]) begin
          gy <= gy >> 1;
        end else if (gx > gy) begin
          gx <= gx - gy;
        end else begin
          gy <= gy - gx;
        end
      end
      OP_GCD_FIN: g <= (gx | gy) << sh;
      OP_DIV_RM: begin dv_q <= r_mag;       dv_rem <= '0; dv_cnt <= '0; end
      OP_DIV_RD: begin dv_q <= r_den;       dv_rem <= '0; dv_cnt <= '0; end
      OP_DIV_AD: begin dv_q <= DW'(a_den);  dv_rem <= '0; dv_cnt <= '0; end
      OP_DIV_BD: begin dv_q <= DW'(b_den);  dv_rem <= '0; dv_cnt <= '0; end
      OP_DIV_STEP: begin
        // restoring division, one quotient bit per cycle
        if (!rem_sub[DW]) begin
          dv_rem <= rem_sub[DW-1:0];
          dv_q   <= {dv_q[DW-2:0], 1'b1};
        end else begin
          dv_rem <= rem_sh[DW-1:0];
          dv_q   <= {dv_q[DW-2:0], 1'b0};
        end
        dv_cnt <= dv_cnt + 1'b1;
      end
      OP_WB_RM: begin
        r_mag <= dv_q;
        r_neg <= r_neg && (dv_q != '0);  // zero is always positive
      end
      OP_WB_RD:   r_den <= dv_q;
      OP_WB_Q1:   q1 <= dv_q[W-1:0];
      OP_WB_Q2:   q2 <= dv_q[W-1:0];
      OP_MUL_T1:  t1 <= prod;
      OP_MUL_T2:  t2 <= prod;
      OP_MUL_DEN: r_den <= prod;
      OP_MUL_MM,
      OP_MUL_MD: begin r_mag <= prod; r_neg <= a_neg ^ b_neg; end
      OP_MUL_DD,
      OP_MUL_DM:  r_den <= prod;
      OP_MUL_CX:  t1 <= prod;
      OP_MUL_CY:  t2 <= prod;
      OP_ADD_COMB: begin
        priority if (a_neg == bneg_eff) begin
          r_neg <= a_neg;    r_mag <= t1 + t2;
        end else if (t1 >= t2) begin
          r_neg <= a_neg;    r_mag <= t1 - t2;
        end else begin
          r_neg <= bneg_eff; r_mag <= t2 - t1;
        end
      end
      OP_FIN_ARITH: begin
        if (ovf) begin
          res <= '{res_num: '0, res_den: '0, cmp_true: 1'b0, status: ST_OVF};
        end else begin
          res <= '{res_num: NUM_BITS'(rnum_w), res_den: DEN_BITS'(r_den[W-2:0]),
                   cmp_true: 1'b0, status: ST_OK};
        end
      end
      OP_FIN_CMP: begin
        res.res_num <= '0;
        res.res_den <= '0;
        res.status  <= ST_OK;
        unique case (cmd)
          CMD_EQ:  res.cmp_true <= (cx == cy);
          CMD_NE:  res.cmp_true <= (cx != cy);
          CMD_LT:  res.cmp_true <= (cx < cy);
          default: res.cmp_true <= (cx > cy);
        endcase
      end
      OP_FIN_ERR:  res <= '{res_num: '0, res_den: '0, cmp_true: 1'b0, status: ST_DIV0};
      OP_FIN_ZERO: res <= '{res_num: '0, res_den: '0, cmp_true: 1'b0, status: ST_OK};
      default: ;
    endcase
  end

  assign stat.cmd        = cmd;
  assign stat.a_den_zero = a_dz;
  assign stat.b_den_zero = b_dz;
  assign stat.b_mag_zero = (b_mag == '0);
  assign stat.gcd_done   = (gx == '0) || (gy == '0);
  assign stat.div_done   = (dv_cnt == CNTW'(DW));
  assign out_data        = res;

endmodule

/* design/rau_ctrl.sv */
// Sequencer of the rational unit: handshakes and datapath command stream.
module rau_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  rau_pkg::rau_stat_t stat,
  output rau_pkg::dp_op_t    op
);
  import rau_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_RG, S_GWAIT, S_RD1, S_RD2, S_DWAIT,
    S_SAVE_A, S_LOAD_B, S_SAVE_B, S_DISPATCH,
    S_AQ1, S_AQ2, S_AM1, S_AM2, S_AM3, S_ACOMB,
    S_M2, S_D2, S_C2, S_FIN
  } state_t;

  state_t state, ret, after;
  dp_op_t div_wb, fin_op;
  logic   slot_free, in_err, cmd_bad, only_a;

  assign slot_free = !out_valid || out_ready;
  assign cmd_bad   = stat.cmd > CMD_GT;
  assign only_a    = (stat.cmd == CMD_NORM) || (stat.cmd == CMD_NEG);
  assign in_err    = stat.a_den_zero || (!only_a && stat.b_den_zero);
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    unique case (state)
      S_IDLE:     op = in_valid ? OP_LOAD : OP_NOP;
      S_CHECK:    op = (cmd_bad || in_err) ? OP_NOP : OP_R_FROM_A;
      S_RG:       op = OP_GCD_R;
      S_GWAIT:    op = stat.gcd_done ? OP_GCD_FIN : OP_GCD_STEP;
      S_RD1:      op = OP_DIV_RM;
      S_RD2:      op = OP_DIV_RD;
      S_DWAIT:    op = stat.div_done ? div_wb : OP_DIV_STEP;
      S_SAVE_A:   op = OP_A_FROM_R;
      S_LOAD_B:   op = OP_R_FROM_B;
      S_SAVE_B:   op = OP_B_FROM_R;
      S_DISPATCH: begin
        unique case (stat.cmd)
          CMD_NORM: op = OP_R_FROM_A;
          CMD_NEG:  op = OP_NEG;
          CMD_ADD,
          CMD_SUB:  op = OP_GCD_D;
          CMD_MUL:  op = OP_MUL_MM;
          CMD_DIV:  op = stat.b_mag_zero ? OP_NOP : OP_MUL_MD;
          default:  op = OP_MUL_CX;
        endcase
      end
      S_AQ1:      op = OP_DIV_BD;
      S_AQ2:      op = OP_DIV_AD;
      S_AM1:      op = OP_MUL_T1;
      S_AM2:      op = OP_MUL_T2;
      S_AM3:      op = OP_MUL_DEN;
      S_ACOMB:    op = OP_ADD_COMB;
      S_M2:       op = OP_MUL_DD;
      S_D2:       op = OP_MUL_DM;
      S_C2:       op = OP_MUL_CY;
      S_FIN:      op = slot_free ? fin_op : OP_NOP;
      default:    op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      after     <= S_IDLE;
      div_wb    <= OP_NOP;
      fin_op    <= OP_FIN_ZERO;
      out_valid <= 1'b0;
    end else begin
      // S_FIN refills the output slot itself when it frees up
      if (out_valid && out_ready && (state != S_FIN)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) state <= S_CHECK;
        S_CHECK: begin
          priority if (cmd_bad) begin
            fin_op <= OP_FIN_ZERO; state <= S_FIN;
          end else if (in_err) begin
            fin_op <= OP_FIN_ERR;  state <= S_FIN;
          end else begin
            ret <= S_SAVE_A; state <= S_RG;
          end
        end
        // reduce subroutine: gcd, then divide numerator and denominator by it
        S_RG:    begin after <= S_RD1; state <= S_GWAIT; end
        S_GWAIT: if (stat.gcd_done) state <= after;
        S_RD1:   begin div_wb <= OP_WB_RM; after <= S_RD2; state <= S_DWAIT; end
        S_RD2:   begin div_wb <= OP_WB_RD; after <= ret;   state <= S_DWAIT; end
        S_DWAIT: if (stat.div_done) state <= after;
        S_SAVE_A: state <= only_a ? S_DISPATCH : S_LOAD_B;
        S_LOAD_B: begin ret <= S_SAVE_B; state <= S_RG; end
        S_SAVE_B: state <= S_DISPATCH;
        S_DISPATCH: begin
          unique case (stat.cmd)
            CMD_NORM,
            CMD_NEG: begin fin_op <= OP_FIN_ARITH; state <= S_FIN; end
            CMD_ADD,
            CMD_SUB: begin after <= S_AQ1; state <= S_GWAIT; end
            CMD_MUL: state <= S_M2;
            CMD_DIV: begin
              if (stat.b_mag_zero) begin
                fin_op <= OP_FIN_ERR; state <= S_FIN;
              end else begin
                state <= S_D2;
              end
            end
            default: state <= S_C2;
          endcase
        end
        S_AQ1:   begin div_wb <= OP_WB_Q1; after <= S_AQ2; state <= S_DWAIT; end
        S_AQ2:   begin div_wb <= OP_WB_Q2; after <= S_AM1; state <= S_DWAIT; end
        S_AM1:   state <= S_AM2;
        S_AM2:   state <= S_AM3;
        S_AM3:   state <= S_ACOMB;
        S_ACOMB, S_M2, S_D2: begin
          fin_op <= OP_FIN_ARITH; ret <= S_FIN; state <= S_RG;
        end
        S_C2:    begin fin_op <= OP_FIN_CMP; state <= S_FIN; end
        S_FIN: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/rau_checker.sv */
// Port-level checks of the rational unit and their bind to the top level.
module rau_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input rau_pkg::rau_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input rau_pkg::rau_out_t out_data
);
  import rau_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != ST_OK) |->
      (out_data.res_num == '0) && (out_data.res_den == '0) && !out_data.cmp_true)
    else $error("error result carries data");

  a_cmp_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.cmp_true |->
      (out_data.res_den == '0) && (out_data.status == ST_OK))
    else $error("compare result carries a fraction");

endmodule

bind rational_arithmetic_unit_top rau_checker u_chk (.*);
